[rtl/rffp_pkg.sv]
// ----------------------------------------------------------------------------
// rffp_pkg
// Shared types and constants of the repeat-first-field pulldown sequencer.
// ----------------------------------------------------------------------------
package rffp_pkg;

  localparam int SRC_W   = 24;
  localparam int OIDX_W  = 26;
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // Kind of one field entry
  typedef enum logic [1:0] {
    KIND_PROG = 2'd0,
    KIND_TOP  = 2'd1,
    KIND_BOT  = 2'd2
  } kind_t;

  // Field order code on the output word
  typedef enum logic [1:0] {
    ORDER_SAME = 2'd0,
    ORDER_BFF  = 2'd1,
    ORDER_TFF  = 2'd2
  } order_t;

  // Input word: picture flags of one coded frame
  typedef struct packed {
    logic repeat_first_field;
    logic top_field_first;
    logic prog_frame;
    logic prog_seq;
  } in_t;

  // Output word: one output frame
  typedef struct packed {
    logic [OIDX_W-1:0] out_frame_index;
    logic [SRC_W-1:0]  top_source_frame;
    logic [SRC_W-1:0]  bottom_source_frame;
    logic              same_source;
    logic [1:0]        field_order;
    logic              last;
  } out_t;

  // Classified coded frame, handed from front to back
  typedef struct packed {
    logic             pend_valid;
    logic [SRC_W-1:0] pend_src;
    kind_t            pend_kind;
    logic [SRC_W-1:0] cur_src;
    logic             prog;
    logic             tff;
    logic [1:0]       npairs;
  } desc_t;

  // Queue status
  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              empty;
    logic              full;
  } qstat_t;

endpackage

[rtl/rffp_front.sv]
// ----------------------------------------------------------------------------
// rffp_front
// Accepts coded frames, tracks the leftover field and the coded frame
// counter, and builds one descriptor per coded frame.
// ----------------------------------------------------------------------------
module rffp_front #(
  parameter int FRAME_INDEX_BITS = 24
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic           cfg_bit,
  input  logic           push,
  input  rffp_pkg::in_t  in_word,
  output rffp_pkg::desc_t desc
);
  import rffp_pkg::*;

  logic                        h264_r;
  logic                        pend_valid_r, pend_valid_nxt;
  logic [SRC_W-1:0]            pend_src_r;
  kind_t                       pend_kind_r, pend_kind_nxt;
  logic [FRAME_INDEX_BITS-1:0] coded_cnt_r;

  logic             prog;
  logic [2:0]       count;
  logic [2:0]       n_entries;
  logic [SRC_W-1:0] cur_src;

  // Classify the coded frame
  always_comb begin
    cur_src   = SRC_W'(coded_cnt_r);
    prog      = in_word.prog_seq | (in_word.prog_frame & h264_r);
    if (prog) begin
      count = in_word.repeat_first_field ? (in_word.top_field_first ? 3'd6 : 3'd4) : 3'd2;
    end else begin
      count = in_word.repeat_first_field ? 3'd3 : 3'd2;
    end
    n_entries = count + {2'b00, pend_valid_r};

    // odd total leaves the last entry of this frame waiting
    pend_valid_nxt = n_entries[0];
    if (prog) begin
      pend_kind_nxt = KIND_PROG;
    end else if (in_word.repeat_first_field == in_word.top_field_first) begin
      pend_kind_nxt = KIND_TOP;
    end else begin
      pend_kind_nxt = KIND_BOT;
    end

    desc.pend_valid = pend_valid_r;
    desc.pend_src   = pend_src_r;
    desc.pend_kind  = pend_kind_r;
    desc.cur_src    = cur_src;
    desc.prog       = prog;
    desc.tff        = in_word.top_field_first;
    desc.npairs     = n_entries[2:1];
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h264_r <= 1'b0;
    end else if (cfg_we) begin
      h264_r <= cfg_bit;
    end
  end

  // Leftover field and coded frame counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      pend_src_r   <= '0;
      pend_kind_r  <= KIND_PROG;
      coded_cnt_r  <= '0;
    end else if (push) begin
      pend_valid_r <= pend_valid_nxt;
      pend_src_r   <= cur_src;
      pend_kind_r  <= pend_kind_nxt;
      coded_cnt_r  <= coded_cnt_r + 1'b1;
    end
  end

endmodule

[rtl/rffp_queue.sv]
// ----------------------------------------------------------------------------
// rffp_queue
// Short register queue of descriptors between front and back.
// ----------------------------------------------------------------------------
module rffp_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  rffp_pkg::desc_t  wr_desc,
  input  logic             pop,
  output rffp_pkg::desc_t  rd_desc,
  output rffp_pkg::qstat_t stat
);
  import rffp_pkg::*;

  desc_t             slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign rd_desc    = slot_r[rd_ptr_r];
  assign stat.count = count_r;
  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == QCNT_W'(QDEPTH));

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_desc;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

[rtl/rffp_back.sv]
// ----------------------------------------------------------------------------
// rffp_back
// Walks the field pairs of the head descriptor, one output frame per cycle
// while out_stall is low, into the output register.
// ----------------------------------------------------------------------------
module rffp_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            head_valid,
  input  rffp_pkg::desc_t head,
  output logic            pop,
  output logic [1:0]      pair_idx,
  output logic            out_valid,
  input  logic            out_stall,
  output rffp_pkg::out_t  out_data
);
  import rffp_pkg::*;

  logic              out_valid_r, out_valid_nxt;
  out_t              out_data_r, out_data_nxt;
  logic [1:0]        pair_r, pair_nxt;
  logic [OIDX_W-1:0] oidx_r;
  logic              load;
  logic              is_last;

  logic [2:0]       e0, e1;
  kind_t            k0, k1;
  logic [SRC_W-1:0] s0, s1;
  logic             swapped, same;

  // Kind of entry e of the head frame's list
  function automatic kind_t entry_kind(desc_t d, logic [2:0] e);
    logic [2:0] j;
    j = e - {2'b00, d.pend_valid};
    if (d.pend_valid && e == 3'd0) begin
      return d.pend_kind;
    end else if (d.prog) begin
      return KIND_PROG;
    end else if ((j == 3'd1) == d.tff) begin
      return KIND_BOT;
    end else begin
      return KIND_TOP;
    end
  endfunction

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign pair_idx  = pair_r;

  // Build the current pair
  always_comb begin
    e0      = {pair_r, 1'b0};
    e1      = {pair_r, 1'b1};
    k0      = entry_kind(head, e0);
    k1      = entry_kind(head, e1);
    s0      = (head.pend_valid && pair_r == 2'd0) ? head.pend_src : head.cur_src;
    s1      = head.cur_src;
    swapped = (k0 == KIND_BOT);
    same    = (s0 == s1);
    is_last = (pair_r == head.npairs - 2'd1);
    load    = head_valid && (!out_valid_r || !out_stall);
    pop     = load && is_last;

    out_data_nxt.out_frame_index     = oidx_r;
    out_data_nxt.top_source_frame    = swapped ? s1 : s0;
    out_data_nxt.bottom_source_frame = swapped ? s0 : s1;
    out_data_nxt.same_source         = same;
    out_data_nxt.field_order         = same ? ORDER_SAME : (swapped ? ORDER_BFF : ORDER_TFF);
    out_data_nxt.last                = is_last;

    if (load) begin
      out_valid_nxt = 1'b1;
      pair_nxt      = is_last ? 2'd0 : pair_r + 2'd1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
      pair_nxt      = pair_r;
    end
  end

  // Output register and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pair_r      <= 2'd0;
      oidx_r      <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pair_r      <= pair_nxt;
      if (load) oidx_r <= oidx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_data_r <= out_data_nxt;
  end

endmodule

[rtl/rff_field_pulldown_sequencer.sv]
// ----------------------------------------------------------------------------
// rff_field_pulldown_sequencer
// Expands coded frame picture flags into field pairs and reports the source
// coded frames of each output frame.
// ----------------------------------------------------------------------------
// Data path: an accepted coded frame is written to the queue, and its output
//   words are loaded from the queue head into the output register.
// Throughput: one output frame per cycle while out_stall is low; each coded
//   frame yields 1 to 3 output frames (field pairs).
// Reset: synchronous, active low; clears counters, leftover field, queue,
//   and the codec register.
module rff_field_pulldown_sequencer #(
  parameter int FRAME_INDEX_BITS = 24
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  rffp_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output rffp_pkg::out_t  out_data,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic            cfg_data
);
  import rffp_pkg::*;

  logic   push, pop;
  desc_t  wr_desc, head;
  qstat_t qstat;
  logic [1:0] pair_idx;

  assign cfg_ready = 1'b1;
  assign in_stall  = qstat.full;
  assign push      = in_valid && !qstat.full;

  rffp_front #(
    .FRAME_INDEX_BITS(FRAME_INDEX_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_we  (cfg_valid && cfg_ready),
    .cfg_bit (cfg_data),
    .push    (push),
    .in_word (in_data),
    .desc    (wr_desc)
  );

  rffp_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .wr_desc (wr_desc),
    .pop     (pop),
    .rd_desc (head),
    .stat    (qstat)
  );

  rffp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (!qstat.empty),
    .head       (head),
    .pop        (pop),
    .pair_idx   (pair_idx),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  // Queue never overfills
  a_qcount: assert property (@(posedge clk) disable iff (!rst_n)
    qstat.count <= QCNT_W'(QDEPTH))
    else $error("queue count beyond depth");

  // A partially walked descriptor stays at the queue head
  a_pair_head: assert property (@(posedge clk) disable iff (!rst_n)
    pair_idx != 2'd0 |-> !qstat.empty && pair_idx < head.npairs)
    else $error("pair index without head descriptor");

  // Pop only on the last pair of the head
  a_pop: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !qstat.empty && pair_idx == head.npairs - 2'd1)
    else $error("pop before last pair");

endmodule
